/* src/npts_pkg.sv */
package npts_pkg;

  localparam int WORD_BITS = 32;
  localparam int DW        = 2 * WORD_BITS;
  localparam int FRAC_BITS = 16;
  localparam int LN_Q      = 30;
  localparam int DVS_BITS  = WORD_BITS + 2;
  localparam int KT_BITS   = 31;
  localparam int Q_BITS    = 31;
  localparam int DOF_BITS  = 21;

  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [DW-1:0]        dword_t;

  localparam dword_t ONE_FX  = dword_t'(1) <<< FRAC_BITS;
  localparam dword_t WMAX    = (dword_t'(1) <<< (WORD_BITS - 1)) - dword_t'(1);
  localparam dword_t WMIN    = -WMAX - dword_t'(1);
  localparam word_t  LN2_Q30 = word_t'(744261118);
  localparam logic [DOF_BITS-1:0] DOF_RST = DOF_BITS'(3);

  typedef enum logic [2:0] {
    ACT_L1   = 3'd0,
    ACT_L2   = 3'd1,
    ACT_L3   = 3'd2,
    ACT_RST  = 3'd3,
    ACT_LOAD = 3'd4
  } action_t;

  localparam logic [1:0] ERR_NONE = 2'd0;
  localparam logic [1:0] ERR_DIV  = 2'd1;
  localparam logic [1:0] ERR_LN   = 2'd2;
  localparam logic [1:0] ERR_SAT  = 2'd3;

  localparam logic [1:0] CFG_KT  = 2'd0;
  localparam logic [1:0] CFG_Q   = 2'd1;
  localparam logic [1:0] CFG_DOF = 2'd2;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef enum logic [5:0] {
    ST_IDLE, ST_GKT, ST_DISP,
    ST_L1_SQ, ST_L1_SQW, ST_L1_DIV, ST_L1_T2, ST_L1_T2W, ST_L1_IN1, ST_L1_IN2,
    ST_L1_TM, ST_L1_TMW,
    ST_L2_MUL, ST_L2_W, ST_PS_SUB,
    ST_L3_TP, ST_L3_TPW, ST_L3_DIV1, ST_L3_CF, ST_L3_DIV2, ST_L3_CC, ST_L3_CCW,
    ST_L3_SC, ST_L3_SCW,
    ST_END, ST_END_PP, ST_END_DIV, ST_END_LN, ST_END_EP, ST_END_EPW, ST_H0, ST_OUT,
    ST_LN_INIT, ST_LN_NORM, ST_LN_SQ, ST_LN_SQW, ST_LN_E, ST_LN_EW, ST_LN_FW
  } state_t;

  function automatic dword_t sx(input word_t v);
    return dword_t'(v);
  endfunction

  function automatic word_t sat_w(input dword_t v);
    if (v > WMAX) return WMAX[WORD_BITS-1:0];
    if (v < WMIN) return WMIN[WORD_BITS-1:0];
    return v[WORD_BITS-1:0];
  endfunction

  function automatic logic ovf_w(input dword_t v);
    return (v > WMAX) || (v < WMIN);
  endfunction

endpackage

/* src/npts_mul.sv */
module npts_mul import npts_pkg::*; (
  input  logic   clk,
  input  word_t  a,
  input  word_t  b,
  output dword_t p
);

  always_ff @(posedge clk) begin
    p <= dword_t'(a) * dword_t'(b);
  end

endmodule

/* src/npts_div.sv */
module npts_div import npts_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  dword_t                     dividend,
  input  logic signed [DVS_BITS-1:0] divisor,
  output div_stat_t                  stat,
  output dword_t                     quotient
);

  localparam int CNT_BITS = $clog2(DW);

  logic [CNT_BITS-1:0] cnt;
  logic                busy;
  logic                done;
  logic                neg;
  logic [DW-1:0]       quo;
  logic [DVS_BITS-1:0] dsr;
  logic [DVS_BITS-1:0] rem;
  logic [DVS_BITS:0]   shifted;
  logic [DVS_BITS:0]   diff;
  logic                take;

  assign shifted = {rem, quo[DW-1]};
  assign diff    = shifted - {1'b0, dsr};
  assign take    = !diff[DVS_BITS];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_BITS'(DW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring divide on magnitudes, one quotient bit per cycle
  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[DW-1] ^ divisor[DVS_BITS-1];
      quo <= dividend[DW-1] ? -dividend : dividend;
      dsr <= divisor[DVS_BITS-1] ? -divisor : divisor;
      rem <= '0;
    end else if (busy) begin
      rem <= take ? diff[DVS_BITS-1:0] : shifted[DVS_BITS-1:0];
      quo <= {quo[DW-2:0], take};
    end
  end

  assign quotient  = neg ? -dword_t'(quo) : dword_t'(quo);
  assign stat.busy = busy;
  assign stat.done = done;

`ifndef NO_ASSERTIONS
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("divider restarted while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("divider done longer than one cycle");
  a_busy_src: assert property (@(posedge clk) disable iff (rst) $rose(busy) |-> $past(start))
    else $error("divider busy without start");
`endif

endmodule

/* src/nose_poincare_thermostat_step.sv */
// Each item runs from input transaction to result through a radix-2 divider and a
// 30-step squaring logarithm; the logarithm and all other products share one 32x32
// multiplier, while the divider has its own datapath.
// One item at a time: the next item is taken once the result is registered.
// Synchronous reset: s = 1.0, ps = 0, H0 = 0, kT = 1.0, Q = 1.0, g = 3.
module nose_poincare_thermostat_step import npts_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [191:0] s_tdata,  // tau, kinetic_energy, potential_energy, load_s, load_ps, load_h0
  input  logic [2:0]   s_tuser,  // action
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [159:0] m_tdata,  // s_value, ps_value, thermostat_kinetic, thermostat_potential, h0_value
  output logic [1:0]   m_tuser,  // error_flag
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [1:0]   cfg_index,
  input  logic [30:0]  cfg_data
);

  state_t state, state_next, ln_ret;

  logic [KT_BITS-1:0]  kt;
  logic [Q_BITS-1:0]   qm;
  logic [DOF_BITS-1:0] dof;
  word_t s_reg, ps_reg, h0_reg;
  logic [2:0] act;
  word_t tau, ek, ep, gkt, xa, t1, ekth, epth, ln_val;
  logic hit_div, hit_ln, hit_sat;

  logic [WORD_BITS-2:0] nm;
  logic [4:0]           ncnt;
  logic [4:0]           lcnt;
  logic [LN_Q-1:0]      frac;
  dword_t               lnacc;

  word_t  mul_a, mul_b;
  dword_t p;
  word_t  p_fx;
  logic   p_fx_ovf;
  logic   div_go;
  dword_t div_dvd, div_q;
  logic signed [DVS_BITS-1:0] div_dvs, two_q;
  div_stat_t dstat;
  word_t  q_sat;
  logic   q_ovf;
  dword_t one_ln, cf_dw, in1_dw, in2_dw, ps_dw, h0_dw;
  word_t  cf, ln_e;

  npts_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(p));

  npts_div u_div (
    .clk(clk), .rst(rst), .start(div_go), .dividend(div_dvd), .divisor(div_dvs),
    .stat(dstat), .quotient(div_q)
  );

  assign s_tready  = (state == ST_IDLE);
  assign cfg_ready = 1'b1;

  assign two_q    = {2'b00, qm, 1'b0};
  assign p_fx     = sat_w(p >>> FRAC_BITS);
  assign p_fx_ovf = ovf_w(p >>> FRAC_BITS);
  assign q_sat    = sat_w(div_q);
  assign q_ovf    = ovf_w(div_q);
  assign one_ln   = ONE_FX + sx(ln_val);
  assign cf_dw    = ONE_FX + sx(xa);
  assign cf       = sat_w(cf_dw);
  assign in1_dw   = sx(xa) - sx(t1);
  assign in2_dw   = sx(xa) - sx(h0_reg);
  assign ps_dw    = sx(ps_reg) - sx(xa);
  assign h0_dw    = sx(ek) + sx(ep) + sx(ekth) + sx(epth);
  assign ln_e     = word_t'(LN_Q - FRAC_BITS) - word_t'(ncnt);

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      ln_ret <= ST_IDLE;
    end else begin
      state <= state_next;
      if (state == ST_L1_DIV) begin
        ln_ret <= ST_L1_T2;
      end else if (state == ST_END_LN) begin
        ln_ret <= ST_END_EP;
      end
    end
  end

  always_comb begin
    state_next = state;
    mul_a      = '0;
    mul_b      = '0;
    div_go     = 1'b0;
    div_dvd    = '0;
    div_dvs    = '0;
    unique case (state)
      ST_IDLE:    if (s_tvalid) state_next = ST_GKT;
      ST_GKT: begin
        mul_a      = {1'b0, kt};
        mul_b      = {{(WORD_BITS-DOF_BITS){1'b0}}, dof};
        state_next = ST_DISP;
      end
      ST_DISP: begin
        unique case (act)
          ACT_L1:  state_next = ST_L1_SQ;
          ACT_L2:  state_next = ST_L2_MUL;
          ACT_L3:  state_next = (qm == '0) ? ST_END : ST_L3_TP;
          default: state_next = ST_END;
        endcase
      end
      ST_L1_SQ: begin
        mul_a      = s_reg;
        mul_b      = s_reg;
        state_next = ST_L1_SQW;
      end
      ST_L1_SQW: begin
        if (p_fx == '0 || s_reg <= word_t'(0)) begin
          state_next = ST_END;
        end else begin
          div_go     = 1'b1;
          div_dvd    = sx(ek) <<< FRAC_BITS;
          div_dvs    = DVS_BITS'(p_fx);
          state_next = ST_L1_DIV;
        end
      end
      ST_L1_DIV:  if (dstat.done) state_next = ST_LN_INIT;
      ST_L1_T2: begin
        mul_a      = gkt;
        mul_b      = sat_w(one_ln);
        state_next = ST_L1_T2W;
      end
      ST_L1_T2W:  state_next = ST_L1_IN1;
      ST_L1_IN1:  state_next = ST_L1_IN2;
      ST_L1_IN2:  state_next = ST_L1_TM;
      ST_L1_TM: begin
        mul_a      = tau;
        mul_b      = xa;
        state_next = ST_L1_TMW;
      end
      ST_L1_TMW:  state_next = ST_PS_SUB;
      ST_L2_MUL: begin
        mul_a      = tau;
        mul_b      = ep;
        state_next = ST_L2_W;
      end
      ST_L2_W:    state_next = ST_PS_SUB;
      ST_PS_SUB:  state_next = ST_END;
      ST_L3_TP: begin
        mul_a      = tau;
        mul_b      = ps_reg;
        state_next = ST_L3_TPW;
      end
      ST_L3_TPW: begin
        div_go     = 1'b1;
        div_dvd    = p;
        div_dvs    = two_q;
        state_next = ST_L3_DIV1;
      end
      ST_L3_DIV1: if (dstat.done) state_next = ST_L3_CF;
      ST_L3_CF: begin
        if (cf == '0) begin
          state_next = ST_END;
        end else begin
          div_go     = 1'b1;
          div_dvd    = sx(ps_reg) <<< FRAC_BITS;
          div_dvs    = DVS_BITS'(cf);
          state_next = ST_L3_DIV2;
        end
      end
      ST_L3_DIV2: if (dstat.done) state_next = ST_L3_CC;
      ST_L3_CC: begin
        mul_a      = t1;
        mul_b      = t1;
        state_next = ST_L3_CCW;
      end
      ST_L3_CCW:  state_next = ST_L3_SC;
      ST_L3_SC: begin
        mul_a      = s_reg;
        mul_b      = t1;
        state_next = ST_L3_SCW;
      end
      ST_L3_SCW:  state_next = ST_END;
      ST_END: begin
        mul_a      = ps_reg;
        mul_b      = ps_reg;
        state_next = (qm == '0) ? ST_END_LN : ST_END_PP;
      end
      ST_END_PP: begin
        div_go     = 1'b1;
        div_dvd    = p;
        div_dvs    = two_q;
        state_next = ST_END_DIV;
      end
      ST_END_DIV: if (dstat.done) state_next = ST_END_LN;
      ST_END_LN:  state_next = (s_reg <= word_t'(0)) ? ST_H0 : ST_LN_INIT;
      ST_END_EP: begin
        mul_a      = gkt;
        mul_b      = ln_val;
        state_next = ST_END_EPW;
      end
      ST_END_EPW: state_next = ST_H0;
      ST_H0:      state_next = ST_OUT;
      ST_OUT:     if (!m_tvalid || m_tready) state_next = ST_IDLE;
      ST_LN_INIT: state_next = ST_LN_NORM;
      ST_LN_NORM: if (nm[WORD_BITS-2]) state_next = ST_LN_SQ;
      ST_LN_SQ: begin
        mul_a      = {1'b0, nm};
        mul_b      = {1'b0, nm};
        state_next = ST_LN_SQW;
      end
      ST_LN_SQW:  state_next = (lcnt == 5'(LN_Q - 1)) ? ST_LN_E : ST_LN_SQ;
      ST_LN_E: begin
        mul_a      = ln_e;
        mul_b      = LN2_Q30;
        state_next = ST_LN_EW;
      end
      ST_LN_EW: begin
        mul_a      = {{(WORD_BITS-LN_Q){1'b0}}, frac};
        mul_b      = LN2_Q30;
        state_next = ST_LN_FW;
      end
      ST_LN_FW:   state_next = ln_ret;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      kt       <= ONE_FX[KT_BITS-1:0];
      qm       <= ONE_FX[Q_BITS-1:0];
      dof      <= DOF_RST;
      s_reg    <= ONE_FX[WORD_BITS-1:0];
      ps_reg   <= '0;
      h0_reg   <= '0;
      hit_div  <= 1'b0;
      hit_ln   <= 1'b0;
      hit_sat  <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_KT:  kt  <= cfg_data;
          CFG_Q:   qm  <= cfg_data;
          CFG_DOF: dof <= cfg_data[DOF_BITS-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && state != ST_OUT) m_tvalid <= 1'b0;
      case (state)
        ST_IDLE: begin
          if (s_tvalid) begin
            act     <= s_tuser;
            tau     <= s_tdata[31:0];
            ek      <= s_tdata[63:32];
            ep      <= s_tdata[95:64];
            hit_div <= 1'b0;
            hit_ln  <= 1'b0;
            hit_sat <= 1'b0;
            if (s_tuser == ACT_LOAD) begin
              s_reg  <= s_tdata[127:96];
              ps_reg <= s_tdata[159:128];
              h0_reg <= s_tdata[191:160];
            end
          end
        end
        ST_DISP: begin
          gkt <= sat_w(p);  // g*kT clips without raising the flag
          if (act == ACT_L3 && qm == '0) hit_div <= 1'b1;
        end
        ST_L1_SQW: begin
          if (p_fx_ovf) hit_sat <= 1'b1;
          if (p_fx == '0) hit_div <= 1'b1;
          else if (s_reg <= word_t'(0)) hit_ln <= 1'b1;
        end
        ST_L1_DIV: begin
          if (dstat.done) begin
            t1 <= q_sat;
            if (q_ovf) hit_sat <= 1'b1;
          end
        end
        ST_L1_T2:   if (ovf_w(one_ln)) hit_sat <= 1'b1;
        ST_L1_T2W, ST_L1_TMW, ST_L2_W: begin
          xa <= p_fx;
          if (p_fx_ovf) hit_sat <= 1'b1;
        end
        ST_L1_IN1: begin
          xa <= sat_w(in1_dw);
          if (ovf_w(in1_dw)) hit_sat <= 1'b1;
        end
        ST_L1_IN2: begin
          xa <= sat_w(in2_dw);
          if (ovf_w(in2_dw)) hit_sat <= 1'b1;
        end
        ST_PS_SUB: begin
          ps_reg <= sat_w(ps_dw);
          if (ovf_w(ps_dw)) hit_sat <= 1'b1;
        end
        ST_L3_DIV1, ST_L3_DIV2: begin
          if (dstat.done) begin
            xa <= q_sat;
            if (q_ovf) hit_sat <= 1'b1;
          end
        end
        ST_L3_CF: begin
          t1 <= cf;
          if (ovf_w(cf_dw)) hit_sat <= 1'b1;
          if (cf == '0) hit_div <= 1'b1;
        end
        ST_L3_CCW: begin
          t1 <= p_fx;
          if (p_fx_ovf) hit_sat <= 1'b1;
        end
        ST_L3_SCW: begin
          s_reg  <= p_fx;
          ps_reg <= xa;
          if (p_fx_ovf) hit_sat <= 1'b1;
        end
        ST_END: begin
          if (qm == '0) begin
            hit_div <= 1'b1;
            ekth    <= '0;
          end
        end
        ST_END_DIV: begin
          if (dstat.done) begin
            ekth <= q_sat;
            if (q_ovf) hit_sat <= 1'b1;
          end
        end
        ST_END_LN: begin
          if (s_reg <= word_t'(0)) begin
            hit_ln <= 1'b1;
            epth   <= '0;
          end
        end
        ST_END_EPW: begin
          epth <= p_fx;
          if (p_fx_ovf) hit_sat <= 1'b1;
        end
        ST_H0: begin
          if (act == ACT_RST && qm != '0 && s_reg > word_t'(0)) begin
            h0_reg <= sat_w(h0_dw);
            if (ovf_w(h0_dw)) hit_sat <= 1'b1;
          end
        end
        ST_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {h0_reg, epth, ekth, ps_reg, s_reg};
            m_tuser  <= hit_div ? ERR_DIV : (hit_ln ? ERR_LN : (hit_sat ? ERR_SAT : ERR_NONE));
          end
        end
        ST_LN_INIT: begin
          nm   <= s_reg[WORD_BITS-2:0];
          ncnt <= '0;
        end
        ST_LN_NORM: begin
          if (!nm[WORD_BITS-2]) begin
            nm   <= {nm[WORD_BITS-3:0], 1'b0};
            ncnt <= ncnt + 1'b1;
          end else begin
            lcnt <= '0;
          end
        end
        ST_LN_SQW: begin
          // square in Q30; a result >= 2 is halved and yields a one bit of log2
          nm   <= p[2*LN_Q+1] ? p[2*LN_Q+1:LN_Q+1] : p[2*LN_Q:LN_Q];
          frac <= {frac[LN_Q-2:0], p[2*LN_Q+1]};
          lcnt <= lcnt + 1'b1;
        end
        ST_LN_EW:   lnacc  <= p;
        ST_LN_FW:   ln_val <= word_t'((lnacc + (p >>> LN_Q)) >>> (LN_Q - FRAC_BITS));
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_accept_seq: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> (state == ST_GKT))
    else $error("accepted transaction did not start the sequencer");
  a_done_wait: assert property (@(posedge clk) disable iff (rst)
    dstat.done |-> (state == ST_L1_DIV || state == ST_L3_DIV1 ||
                    state == ST_L3_DIV2 || state == ST_END_DIV))
    else $error("quotient arrived outside a wait state");
  a_div_flag: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && (!m_tvalid || m_tready) && hit_div) |=> (m_tuser == ERR_DIV))
    else $error("divide error not reported");
`endif

endmodule

/* verif/tb_nose_poincare_thermostat_step.sv */
`timescale 1ns / 1ps

module tb_nose_poincare_thermostat_step;
  import npts_pkg::*;

  localparam longint LIM_HI = 64'sd2147483647;
  localparam longint LIM_LO = -64'sd2147483648;
  localparam longint FX1 = 64'sd65536;
  localparam int DRAIN_CYCLES = 400;
  localparam longint MAX_CYCLES = 5000000;

  typedef struct {
    logic [2:0] act;
    word_t tau, ek, ep, ld_s, ld_ps, ld_h0;
  } step_cmd_t;

  typedef struct {
    word_t s, ps, kin, pot, h0;
    logic [1:0] flag;
  } thermo_out_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [191:0] s_tdata = '0;
  logic [2:0] s_tuser = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [159:0] m_tdata;
  logic [1:0] m_tuser;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [1:0] cfg_index = '0;
  logic [30:0] cfg_data = '0;

  nose_poincare_thermostat_step u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  // thermostat state and register copies
  longint th_s, th_ps, th_h0, kt_val, q_val, dof_val;
  bit hit_div, hit_ln, hit_sat;

  step_cmd_t cmd_q[$];
  thermo_out_t want_q[$];
  step_cmd_t cur_cmd;
  int n_queued = 0, n_taken = 0, errors = 0;
  bit in_taken = 0;
  int send_gap = 0, recv_stall = 0;
  bit burst = 0;
  longint cycles = 0;

  function automatic longint clamp(longint v);
    if (v > LIM_HI) begin hit_sat = 1; return LIM_HI; end
    if (v < LIM_LO) begin hit_sat = 1; return LIM_LO; end
    return v;
  endfunction

  function automatic longint mulfx(longint a, longint b);
    return clamp((a * b) >>> FRAC_BITS);
  endfunction

  function automatic longint divfx(longint a, longint b);
    if (b == 0) begin hit_div = 1; return 0; end
    return clamp((a * FX1) / b);
  endfunction

  // natural log of a positive fixed-point value by repeated squaring
  function automatic longint lnfx(longint x);
    longint unsigned u, m, frac;
    int k;
    longint r;
    u = x; k = 0; frac = 0;
    while ((u >> 1) != 0) begin u = u >> 1; k++; end
    if (k >= 30) m = longint'(x) >> (k - 30);
    else m = longint'(x) << (30 - k);
    for (int i = 1; i <= 30; i++) begin
      m = (m * m) >> 30;
      if (m >= (64'd2 << 30)) begin
        m = m >> 1;
        frac = frac | (64'd1 << (30 - i));
      end
    end
    r = longint'(k - FRAC_BITS) * longint'(LN2_Q30)
        + longint'((frac * longint'(LN2_Q30)) >> 30);
    return r >>> (30 - FRAC_BITS);
  endfunction

  function automatic thermo_out_t thermo_update(step_cmd_t c);
    thermo_out_t o;
    longint two_q, gkt, s2, t1, t2, inner, coeff, nps, kin, pot;
    two_q = 2 * q_val;
    // g*kT clipping does not count toward the item's flag
    gkt = clamp(kt_val * dof_val);
    hit_div = 0; hit_ln = 0; hit_sat = 0;
    kin = 0; pot = 0;
    case (c.act)
      ACT_L1: begin
        s2 = mulfx(th_s, th_s);
        t1 = divfx(longint'(c.ek), s2);
        if (!hit_div) begin
          if (th_s <= 0) hit_ln = 1;
          else begin
            t2 = mulfx(gkt, clamp(FX1 + lnfx(th_s)));
            inner = clamp(clamp(t2 - t1) - th_h0);
            th_ps = clamp(th_ps - mulfx(longint'(c.tau), inner));
          end
        end
      end
      ACT_L2: th_ps = clamp(th_ps - mulfx(longint'(c.tau), longint'(c.ep)));
      ACT_L3: begin
        if (two_q == 0) hit_div = 1;
        else begin
          coeff = clamp(FX1 + clamp((longint'(c.tau) * th_ps) / two_q));
          nps = divfx(th_ps, coeff);
          if (!hit_div) begin
            th_s = mulfx(th_s, mulfx(coeff, coeff));
            th_ps = nps;
          end
        end
      end
      ACT_RST: begin
        if (two_q == 0) hit_div = 1;
        else if (th_s <= 0) hit_ln = 1;
        else th_h0 = clamp(longint'(c.ek) + longint'(c.ep) + clamp((th_ps * th_ps) / two_q)
                           + mulfx(gkt, lnfx(th_s)));
      end
      ACT_LOAD: begin
        th_s = c.ld_s; th_ps = c.ld_ps; th_h0 = c.ld_h0;
      end
      default: ;
    endcase
    if (two_q == 0) hit_div = 1;
    else kin = clamp((th_ps * th_ps) / two_q);
    if (th_s <= 0) hit_ln = 1;
    else pot = mulfx(gkt, lnfx(th_s));
    o.s = word_t'(th_s); o.ps = word_t'(th_ps); o.h0 = word_t'(th_h0);
    o.kin = word_t'(kin); o.pot = word_t'(pot);
    o.flag = hit_div ? ERR_DIV : hit_ln ? ERR_LN : hit_sat ? ERR_SAT : ERR_NONE;
    return o;
  endfunction

  // input side: acceptance and prediction at the rising edge
  always @(posedge clk) begin
    cycles++;
    if (cycles > MAX_CYCLES) begin
      $display("Test completed with failures");
      $finish;
    end
    if (!rst && s_tvalid && s_tready) begin
      want_q.push_back(thermo_update(cur_cmd));
      n_taken++;
      in_taken = 1;
    end
  end

  always @(negedge clk) begin
    if (!rst && (!s_tvalid || in_taken)) begin
      in_taken = 0;
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        cur_cmd = cmd_q.pop_front();
        s_tdata <= {cur_cmd.ld_h0, cur_cmd.ld_ps, cur_cmd.ld_s,
                    cur_cmd.ep, cur_cmd.ek, cur_cmd.tau};
        s_tuser <= cur_cmd.act;
        s_tvalid <= 1'b1;
        if ($urandom_range(0, 15) == 0) burst = !burst;
        send_gap = burst ? 0 : $urandom_range(0, 18);
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // output side
  always @(negedge clk) begin
    if (rst) m_tready <= 1'b0;
    else if (recv_stall > 0) begin
      recv_stall--;
      m_tready <= 1'b0;
    end else m_tready <= 1'b1;
  end

  always @(posedge clk) begin
    thermo_out_t w;
    if (!rst && m_tvalid && m_tready) begin
      recv_stall = burst ? 0 : $urandom_range(0, 18);
      if (want_q.size() == 0) begin
        $error("result transaction with no expected result");
        errors++;
      end else begin
        w = want_q.pop_front();
        if (m_tdata[31:0] !== w.s) begin
          $error("s_value exp %0d got %0d", w.s, $signed(m_tdata[31:0])); errors++;
        end
        if (m_tdata[63:32] !== w.ps) begin
          $error("ps_value exp %0d got %0d", w.ps, $signed(m_tdata[63:32])); errors++;
        end
        if (m_tdata[95:64] !== w.kin) begin
          $error("thermostat_kinetic exp %0d got %0d", w.kin, $signed(m_tdata[95:64]));
          errors++;
        end
        if (m_tdata[127:96] !== w.pot) begin
          $error("thermostat_potential exp %0d got %0d", w.pot, $signed(m_tdata[127:96]));
          errors++;
        end
        if (m_tdata[159:128] !== w.h0) begin
          $error("h0_value exp %0d got %0d", w.h0, $signed(m_tdata[159:128])); errors++;
        end
        if (m_tuser !== w.flag) begin
          $error("error_flag exp %0d got %0d", w.flag, m_tuser); errors++;
        end
      end
    end
  end

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(negedge clk); while (!cfg_ready);
    @(posedge clk);
    case (idx)
      CFG_KT: kt_val = val;
      CFG_Q: q_val = val;
      CFG_DOF: dof_val = val[20:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic queue_cmd(logic [2:0] a, word_t tau, word_t ek, word_t ep,
                           word_t ls, word_t lp, word_t lh);
    step_cmd_t c;
    c.act = a; c.tau = tau; c.ek = ek; c.ep = ep;
    c.ld_s = ls; c.ld_ps = lp; c.ld_h0 = lh;
    cmd_q.push_back(c);
    n_queued++;
  endtask

  task automatic wait_idle();
    while (n_taken != n_queued || want_q.size() > 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // mostly modest Q16.16 values, sometimes extremes or raw bits
  function automatic word_t pick_val(int span);
    case ($urandom_range(0, 9))
      0: return word_t'($urandom());
      1: return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
      default: return word_t'($urandom_range(0, 2 * span)) - word_t'(span);
    endcase
  endfunction

  task automatic queue_random(int n);
    logic [2:0] a;
    word_t s_ld;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 19) == 0) a = 3'($urandom_range(5, 7));
      else a = 3'($urandom_range(ACT_L1, ACT_LOAD));
      // loads usually put s near 1.0 so the steps go on doing real work
      s_ld = ($urandom_range(0, 7) == 0) ? pick_val(70000)
                                         : word_t'($urandom_range(16384, 262144));
      queue_cmd(a, pick_val(8192), pick_val(400000), pick_val(400000),
                s_ld, pick_val(200000), pick_val(400000));
    end
  endtask

  initial begin
    th_s = FX1; th_ps = 0; th_h0 = 0;
    kt_val = 65536; q_val = 65536; dof_val = 3;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed part under the reset settings
    queue_cmd(ACT_L1, 32'sd6554, 32'sd65536, 0, 0, 0, 0);
    queue_cmd(ACT_L2, 32'sd6554, 0, 32'sd131072, 0, 0, 0);
    queue_cmd(ACT_L3, 32'sd6554, 0, 0, 0, 0, 0);
    queue_cmd(ACT_RST, 0, 32'sd65536, 32'sd32768, 0, 0, 0);
    queue_cmd(3'd5, 0, 0, 0, 0, 0, 0);
    queue_cmd(3'd6, 0, 0, 0, 0, 0, 0);
    queue_cmd(3'd7, 0, 0, 0, 0, 0, 0);
    // coeff of zero in L3
    queue_cmd(ACT_LOAD, 0, 0, 0, 32'sd65536, 32'sd65536, 0);
    queue_cmd(ACT_L3, -32'sd131072, 0, 0, 0, 0, 0);
    // s squared underflows to zero
    queue_cmd(ACT_LOAD, 0, 0, 0, 32'sd1, 0, 0);
    queue_cmd(ACT_L1, 32'sd65536, 32'sd65536, 0, 0, 0, 0);
    // nonpositive s in L1 and reset H0
    queue_cmd(ACT_LOAD, 0, 0, 0, -32'sd65536, 32'sd100, 32'sd7);
    queue_cmd(ACT_L1, 32'sd65536, 32'sd65536, 0, 0, 0, 0);
    queue_cmd(ACT_RST, 0, 32'sd65536, 32'sd65536, 0, 0, 0);
    queue_cmd(ACT_LOAD, 0, 0, 0, 0, 0, 0);
    queue_cmd(ACT_RST, 0, 0, 0, 0, 0, 0);
    // extremes and saturation
    queue_cmd(ACT_LOAD, 0, 0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh80000000);
    queue_cmd(ACT_RST, 0, 32'sh7fffffff, 32'sh7fffffff, 0, 0, 0);
    queue_cmd(ACT_L3, 32'sh7fffffff, 0, 0, 0, 0, 0);
    queue_cmd(ACT_LOAD, 0, 0, 0, 32'sh80000000, 32'sh80000000, 32'sh7fffffff);
    queue_cmd(ACT_L2, 32'sh80000000, 0, 32'sh7fffffff, 0, 0, 0);
    queue_cmd(ACT_L2, 32'sh7fffffff, 0, 32'sh80000000, 0, 0, 0);
    queue_cmd(ACT_LOAD, 0, 0, 0, 32'sd65536, 0, 0);
    queue_cmd(ACT_L1, 32'sh80000000, 32'sh80000000, 0, 0, 0, 0);
    wait_idle();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          write_reg(CFG_KT, 31'd65536); write_reg(CFG_Q, 31'd65536);
          write_reg(CFG_DOF, 31'd3);
        end
        1: begin
          write_reg(CFG_KT, 31'h7fffffff); write_reg(CFG_Q, 31'h7fffffff);
          write_reg(CFG_DOF, 31'd1048576);
        end
        2: begin
          write_reg(CFG_KT, 31'd0); write_reg(CFG_Q, 31'd1); write_reg(CFG_DOF, 31'd0);
        end
        default: begin
          write_reg(CFG_KT, 31'($urandom_range(0, 400000)));
          write_reg(CFG_Q, 31'($urandom_range(1, 400000)));
          write_reg(CFG_DOF, 31'($urandom_range(0, 1000)));
        end
      endcase
      queue_cmd(ACT_LOAD, 0, 0, 0, 32'sd65536, 0, 0);
      queue_random(400);
      wait_idle();
    end

    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule
